[rtl/core/sle_pkg.sv]
// Shared types and constants for the sorted list engine.
// No dependencies; imported by every module of the block.
package sle_pkg;

  localparam int DEPTH       = 1024;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 10;
  localparam int KEY_W       = 32;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int GRP         = 32;
  localparam int NGRP        = (DEPTH + GRP - 1) / GRP;
  localparam int GCNT_W      = $clog2(GRP + 1);
  localparam int SUB         = 8;
  localparam int NSUB        = (NGRP + SUB - 1) / SUB;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_GRP,
    S_SUB,
    S_ENC,
    S_UPD
  } state_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] pos;
    logic             found;
  } enc_res_t;

endpackage

[rtl/core/sle_cell.sv]
// One storage cell of the sorted row: holds an entry, compares it to the key,
// and shifts up or down with its neighbors. Depends on sle_pkg.
module sle_cell
  import sle_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             valid,
  input  logic [KEY_W-1:0] left_data,
  input  logic [KEY_W-1:0] right_data,
  input  logic             left_lt,
  input  logic             left_eq,
  output logic [KEY_W-1:0] data,
  output logic             lt,
  output logic             eq,
  output logic             hit
);

  logic [KEY_W-1:0] data_r, data_nxt;
  logic             lt_r, eq_r;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (!left_lt) begin
        data_nxt = left_data;
      end else if (!lt_r) begin
        data_nxt = ctl.key;
      end
    end else if (ctl.rem) begin
      if (!lt_r) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    lt_r   <= valid && ($signed(data_r) < $signed(ctl.key));
    eq_r   <= valid && (data_r == ctl.key);
  end

  assign data = data_r;
  assign lt   = lt_r;
  assign eq   = eq_r;
  // lowest entry of an equal run
  assign hit  = eq_r & ~left_eq;

endmodule

[rtl/core/sle_prio.sv]
// Registered count tree over the cell flags: number of entries below the key
// and whether any entry matches. Three register levels. Depends on sle_pkg.
module sle_prio
  import sle_pkg::*;
(
  input  logic             clk,
  input  logic [DEPTH-1:0] lt,
  input  logic [DEPTH-1:0] hit,
  output enc_res_t         res
);

  logic [NGRP*GRP-1:0] lt_pad, hit_pad;
  logic [GCNT_W-1:0]   gcnt_r [NGRP];
  logic [NGRP-1:0]     ghit_r;
  logic [CNT_W-1:0]    ssum [NSUB];
  logic [NSUB-1:0]     shit;
  logic [CNT_W-1:0]    scnt_r [NSUB];
  logic [NSUB-1:0]     shit_r;
  logic [CNT_W-1:0]    tot;
  enc_res_t            res_r;

  assign lt_pad  = (NGRP*GRP)'(lt);
  assign hit_pad = (NGRP*GRP)'(hit);

  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      gcnt_r[g] <= GCNT_W'($countones(lt_pad[g*GRP +: GRP]));
      ghit_r[g] <= |hit_pad[g*GRP +: GRP];
    end
  end

  always_comb begin
    for (int s = 0; s < NSUB; s++) begin
      ssum[s] = '0;
      shit[s] = 1'b0;
      for (int k = 0; k < SUB; k++) begin
        if (s*SUB + k < NGRP) begin
          ssum[s] = ssum[s] + CNT_W'(gcnt_r[s*SUB + k]);
          shit[s] = shit[s] | ghit_r[s*SUB + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scnt_r <= ssum;
    shit_r <= shit;
  end

  always_comb begin
    tot = '0;
    for (int s = 0; s < NSUB; s++) begin
      tot = tot + scnt_r[s];
    end
  end

  always_ff @(posedge clk) begin
    res_r.pos   <= tot;
    res_r.found <= |shit_r;
  end

  assign res = res_r;

endmodule

[rtl/core/sorted_list_engine.sv]
// Sorted list engine: ascending list of signed 32-bit keys with insert,
// remove and search commands. Depends on sle_pkg, sle_cell, sle_prio.
//
// Usage:
//   Input channel in_*: one beat per command; in_tuser carries the command
//   (insert, remove, search), in_tdata the signed key.
//   Output channel out_*: exactly one beat per command; out_tuser carries the
//   status (ok, not found, list full), out_tdata the position and the entry
//   count after the command.
//   The result shows on out_tvalid once the compare pass over the row of cells,
//   two levels of the count tree and the encode register have run; the row
//   shifts and the output register loads together.
//   in_tready is high only while no command is in flight; a finished result
//   may still sit in the output register while the next command is taken.
//   If out_tready stays low, the shift of the following command waits until
//   the output register frees up, so no result is lost.
//   Reset empties the list (count 0); stored keys need no clearing.
module sorted_list_engine
  import sle_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [31:0] value
  input  logic [CMD_W-1:0]       in_tuser,   // [1:0] command
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] position, [20:10] count
  output logic [STAT_W-1:0]      out_tuser   // [1:0] status
);

  state_t                 state_r, state_nxt;
  logic [CMD_W-1:0]       cmd_r;
  logic [KEY_W-1:0]       key_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic [STAT_W-1:0]      out_tuser_r;

  logic                   upd_go, do_ins, do_rem;
  logic [STAT_W-1:0]      res_stat;
  logic [POS_W-1:0]       res_pos;
  cell_ctl_t              ctl;
  enc_res_t               enc;

  logic [KEY_W-1:0]       cell_data [DEPTH];
  logic [DEPTH-1:0]       cell_lt, cell_eq, cell_hit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_GRP;
      S_GRP:  state_nxt = S_SUB;
      S_SUB:  state_nxt = S_ENC;
      S_ENC:  state_nxt = S_UPD;
      S_UPD:  if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and command decode
  always_comb begin
    in_tready = (state_r == S_IDLE);
    upd_go    = (state_r == S_UPD) && (!out_valid_r || out_tready);
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    res_stat  = STAT_OK;
    res_pos   = '0;
    count_nxt = count_r;
    case (cmd_r)
      CMD_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          res_stat = STAT_FULL;
        end else begin
          do_ins    = 1'b1;
          res_pos   = enc.pos[POS_W-1:0];
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (enc.found) begin
          do_rem    = 1'b1;
          res_pos   = enc.pos[POS_W-1:0];
          count_nxt = count_r - 1'b1;
        end else begin
          res_stat = STAT_MISS;
        end
      end
      CMD_SEARCH: begin
        if (enc.found) begin
          res_pos = enc.pos[POS_W-1:0];
        end else begin
          res_stat = STAT_MISS;
        end
      end
      default: ;
    endcase
    ctl.ins = do_ins & upd_go;
    ctl.rem = do_rem & upd_go;
    ctl.key = key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (upd_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      key_r <= in_tdata[KEY_W-1:0];
    end
    if (upd_go) begin
      out_tdata_r <= OUT_TDATA_W'({count_nxt, res_pos});
      out_tuser_r <= res_stat;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [KEY_W-1:0] left_data, right_data;
    logic             left_lt, left_eq, valid;

    assign valid = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_data = key_r;
      assign left_lt   = 1'b1;
      assign left_eq   = 1'b0;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
      assign left_eq   = cell_eq[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = key_r;
    end else begin : g_up
      assign right_data = cell_data[i+1];
    end

    sle_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (valid),
      .left_data  (left_data),
      .right_data (right_data),
      .left_lt    (left_lt),
      .left_eq    (left_eq),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i]),
      .hit        (cell_hit[i])
    );
  end

  sle_prio u_prio (
    .clk (clk),
    .lt  (cell_lt),
    .hit (cell_hit),
    .res (enc)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[rtl/core/sle_checker.sv]
// Port-level checks for the sorted list engine, bound to the top level.
// Depends on sle_pkg and sorted_list_engine.
module sle_checker
  import sle_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [STAT_W-1:0]      out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while one is in flight");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |-> out_tdata[20:10] == CNT_W'(DEPTH))
    else $error("full status with count below capacity");

  a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != STAT_OK |-> out_tdata[9:0] == '0)
    else $error("nonzero position on failed command");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[20:10] <= CNT_W'(DEPTH))
    else $error("count beyond capacity");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (.*);
